// ----- src/fth_pkg.sv -----
// fth_pkg: shared types and codes of the flow tuple hash table
// no dependencies
`timescale 1ns / 1ps
package fth_pkg;
   localparam logic [1:0] OP_FIND   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam int KEY_W  = 96;
   localparam int HASH_W = 16;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request key and hashed bucket
      logic clr_step;   // sweep one reset entry
      logic rd_head;    // read bucket head
      logic rd_node;    // read current node key and link
      logic advance;    // prev <- cur, cur <- next
      logic do_insert;  // pop, write node, write head
      logic do_unlink;  // splice out cur and push it
      logic set_result; // capture result
      logic [1:0] res_status;
      logic res_handle; // take handle from cur
   } fth_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_done;
      logic pool_empty;
      logic link_ok;   // current link valid
      logic key_match; // current node key equals request key
   } fth_sts_type;
endpackage

// ----- src/fth_datapath.sv -----
// fth_datapath: hash, bucket head memory, node memories, free stack
// depends on fth_pkg
`timescale 1ns / 1ps
module fth_datapath #(
   parameter int BUCKETS = 4096,
   parameter int NODES   = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           req_op,
   input  logic [31:0]          req_src_addr,
   input  logic [31:0]          req_dst_addr,
   input  logic [15:0]          req_src_port,
   input  logic [15:0]          req_dst_port,
   input  fth_pkg::fth_cmd_type cmd,
   output fth_pkg::fth_sts_type sts,
   output logic [1:0]           res_status,
   output logic [11:0]          res_handle
);
   import fth_pkg::*;

   localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CW  = $clog2(NODES + 1);
   localparam int LW  = NW + 1;
   localparam int SW  = (BW > NW) ? BW : NW; // sweep counter covers both

   logic [LW-1:0]     heads_mem [BUCKETS];
   logic [KEY_W-1:0]  keys_mem  [NODES];
   logic [LW-1:0]     next_mem  [NODES];
   logic [NW-1:0]     stack_mem [NODES];

   logic [KEY_W-1:0]  key_ff;
   logic [BW-1:0]     bucket_ff;
   logic [CW-1:0]     count_ff;
   logic [SW:0]       sweep_ff;
   logic [LW-1:0]     cur_ff;      // current link, index and valid
   logic [NW-1:0]     prev_ff;
   logic              has_prev_ff;
   logic [KEY_W-1:0]  nkey_ff;
   logic [LW-1:0]     nnext_ff;
   logic [NW-1:0]     top_ff;      // registered stack top
   logic [1:0]        status_ff;
   logic [11:0]       handle_ff;

   logic [KEY_W-1:0]  key_in;
   logic [HASH_W-1:0] hash;
   logic [15:0]       hi, lo;
   logic [NW-1:0]     cur_idx;
   // head value for insert comes from the cur register loaded by rd_head
   logic [LW-1:0]     heads_mem_rd;

   assign key_in = {req_dst_port, req_src_port, req_dst_addr, req_src_addr};
   assign hi = req_dst_addr[31:16] ^ req_src_addr[31:16];
   assign lo = {8'd0, req_dst_addr[7:0] ^ req_src_addr[7:0]} ^ req_src_port;
   assign hash = {hi[5:0], lo[9:0]};
   assign cur_idx = cur_ff[NW-1:0];
   assign heads_mem_rd = cur_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff    <= key_in;
         bucket_ff <= BW'(32'(hash) % BUCKETS);
      end
   end

   // reset sweep: clear heads, fill stack ascending
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (cmd.clr_step && !sts.clr_done) begin
         sweep_ff <= sweep_ff + 1'b1;
      end
   end
   assign sts.clr_done = (32'(sweep_ff) >= BUCKETS) && (32'(sweep_ff) >= NODES);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CW'(NODES);
      end else if (cmd.do_insert) begin
         count_ff <= count_ff - 1'b1;
      end else if (cmd.do_unlink && 32'(count_ff) < NODES) begin
         count_ff <= count_ff + 1'b1;
      end
   end
   assign sts.pool_empty = (count_ff == '0);

   // bucket heads
   always_ff @(posedge clock) begin
      if (cmd.clr_step && 32'(sweep_ff) < BUCKETS) begin
         heads_mem[sweep_ff[BW-1:0]] <= '0;
      end else if (cmd.do_insert) begin
         heads_mem[bucket_ff] <= {1'b1, top_ff};
      end else if (cmd.do_unlink && !has_prev_ff) begin
         heads_mem[bucket_ff] <= nnext_ff;
      end
      if (cmd.rd_head) begin
         cur_ff      <= heads_mem[bucket_ff];
         has_prev_ff <= 1'b0;
      end else if (cmd.advance) begin
         cur_ff      <= nnext_ff;
         prev_ff     <= cur_idx;
         has_prev_ff <= 1'b1;
      end
   end

   // node memories
   always_ff @(posedge clock) begin
      if (cmd.do_insert) begin
         keys_mem[top_ff] <= key_ff;
         next_mem[top_ff] <= heads_mem_rd;
      end else if (cmd.do_unlink && has_prev_ff) begin
         next_mem[prev_ff] <= nnext_ff;
      end
      if (cmd.rd_node) begin
         nkey_ff  <= keys_mem[cur_idx];
         nnext_ff <= next_mem[cur_idx];
      end
   end

   // free stack
   always_ff @(posedge clock) begin
      if (cmd.clr_step && 32'(sweep_ff) < NODES) begin
         stack_mem[sweep_ff[NW-1:0]] <= sweep_ff[NW-1:0];
      end else if (cmd.do_unlink && 32'(count_ff) < NODES) begin
         stack_mem[count_ff[NW-1:0]] <= cur_idx;
      end
      if (cmd.load) begin
         top_ff <= stack_mem[NW'(count_ff - 1'b1)];
      end
   end

   assign sts.link_ok   = cur_ff[LW-1];
   assign sts.key_match = (nkey_ff == key_ff);

   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         status_ff <= cmd.res_status;
         if (cmd.res_handle) begin
            handle_ff <= 12'(cur_idx);
         end else if (cmd.do_insert) begin
            handle_ff <= 12'(top_ff);
         end else begin
            handle_ff <= '0;
         end
      end
   end
   assign res_status = status_ff;
   assign res_handle = handle_ff;

   logic unused_op;
   assign unused_op = ^req_op;
endmodule

// ----- src/fth_ctrl.sv -----
// fth_ctrl: sequencer for find, insert and delete chain walks
// depends on fth_pkg
`timescale 1ns / 1ps
module fth_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_op,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output fth_pkg::fth_cmd_type cmd,
   input  fth_pkg::fth_sts_type sts
);
   import fth_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HEAD, S_LINK, S_READ, S_CMP, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic       vld_ff, vld_in;

   // result register frees the walker once the previous response is taken
   assign req_tready = (state_ff == S_IDLE) && (!vld_ff || rsp_tready);
   assign rsp_tvalid = vld_ff;

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      vld_in   = vld_ff && !rsp_tready;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               op_in    = req_op;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.rd_head = 1'b1;
            state_in    = S_LINK;
         end
         S_LINK: begin
            if (op_ff == OP_INSERT) begin
               cmd.set_result = 1'b1;
               if (sts.pool_empty) begin
                  cmd.res_status = ST_FULL;
               end else begin
                  cmd.do_insert  = 1'b1;
                  cmd.res_status = ST_OK;
               end
               state_in = S_RESP;
            end else if (!sts.link_ok) begin
               cmd.set_result = 1'b1;
               cmd.res_status = ST_MISS;
               state_in       = S_RESP;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_node = 1'b1;
            state_in    = S_CMP;
         end
         S_CMP: begin
            if (sts.key_match) begin
               cmd.set_result = 1'b1;
               cmd.res_status = ST_OK;
               if (op_ff == OP_DELETE) cmd.do_unlink = 1'b1;
               else cmd.res_handle = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_LINK;
            end
         end
         S_RESP: begin
            vld_in   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         op_ff    <= OP_FIND;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         vld_ff   <= vld_in;
      end
   end
endmodule

// ----- src/flow_tuple_hash_table.sv -----
// channel  dir  payload (low bit first)
// req      in   tdata: op[1:0] src_addr[33:2] dst_addr[65:34] src_port[81:66] dst_port[97:82]
// rsp      out  tdata: status[1:0] node_handle[13:2]
// a find or delete walks the bucket chain and insert links a new node at the
// bucket head; one read of the node memories per visited node.
// after reset a sweep clears the heads and fills the free stack; req_tready
// stays low meanwhile. a waiting response holds off the next transaction
// only until it is taken.
// depends on fth_pkg, fth_ctrl, fth_datapath
`timescale 1ns / 1ps
module flow_tuple_hash_table #(
   parameter int BUCKETS = 4096,
   parameter int NODES   = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // op, src_addr, dst_addr, src_port, dst_port
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata   // status, node_handle
);
   import fth_pkg::*;

   fth_cmd_type cmd;
   fth_sts_type sts;
   logic [1:0]  status;
   logic [11:0] handle;

   fth_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_op(req_tdata[1:0]), .rsp_tvalid, .rsp_tready, .cmd, .sts
   );

   fth_datapath #(.BUCKETS(BUCKETS), .NODES(NODES)) u_dp (
      .clock, .reset,
      .req_op(req_tdata[1:0]),
      .req_src_addr(req_tdata[33:2]),
      .req_dst_addr(req_tdata[65:34]),
      .req_src_port(req_tdata[81:66]),
      .req_dst_port(req_tdata[97:82]),
      .cmd, .sts, .res_status(status), .res_handle(handle)
   );

   assign rsp_tdata = {2'b00, handle, status};

   logic unused_pad;
   assign unused_pad = ^req_tdata[103:98];
endmodule
